>>> rtl/core/qclt_pkg.sv
// ============================================================================
// qclt_pkg: shared types and constants for the command line tokenizer
// Event codes, scan modes, the result word layout and the saturation limits.
// ============================================================================
package qclt_pkg;

    // Line and token limits; counters saturate at these values.
    localparam int MAX_LINE   = 1024;
    localparam int MAX_TOKENS = 255;

    // Saturation caps as seen on the result fields.
    localparam int POS_CAP_I = (MAX_LINE > 2047) ? 2047 : MAX_LINE;
    localparam int TOK_CAP_I = (MAX_TOKENS > 255) ? 255 : MAX_TOKENS;
    localparam logic [10:0] POS_CAP = POS_CAP_I[10:0];
    localparam logic [7:0]  TOK_CAP = TOK_CAP_I[7:0];

    // Byte codes that steer the scanner.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_BETWEEN    = 3'd0,
        MODE_PLAIN      = 3'd1,
        MODE_QUOTED     = 3'd2,
        MODE_QUOTE_SEEN = 3'd3,
        MODE_SKIP       = 3'd4
    } t_mode;

    // Event kinds carried by a result word.
    typedef enum logic [2:0] {
        EV_BYTE  = 3'd0,
        EV_END   = 3'd1,
        EV_OK    = 3'd2,
        EV_ILL   = 3'd3,
        EV_NOCMD = 3'd4
    } t_event;

    // One result word.
    typedef struct packed {
        t_event      kind;
        logic [7:0]  ch;
        logic [10:0] pos;
        logic [7:0]  tok;
        logic        last;
    } t_result;

    // All results caused by one input byte, in order, and how many there are.
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_burst;

    // Build a result word; the last flag is set later by the caller.
    function automatic t_result make_result(t_event kind, logic [7:0] ch,
                                            logic [10:0] pos, logic [7:0] tok);
        t_result r;
        r.kind = kind;
        r.ch   = ch;
        r.pos  = pos;
        r.tok  = tok;
        r.last = 1'b0;
        return r;
    endfunction

    // Token counter increment that sticks at its cap.
    function automatic logic [7:0] tok_inc(logic [7:0] t);
        return (t < TOK_CAP) ? t + 8'd1 : t;
    endfunction

endpackage

>>> rtl/core/qclt_scan.sv
// ============================================================================
// qclt_scan: scanner state and per-byte decode
// Holds the scan mode, byte position and token count, and turns one byte into
// the ordered list of up to three result words that it causes.
// ============================================================================
module qclt_scan import qclt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_byte,
    input  logic       i_eol,
    output t_burst     o_burst
);

    t_mode       r_mode, n_mode;
    logic [10:0] r_pos, n_pos;
    logic [7:0]  r_tok, n_tok;

    logic        sep;
    logic        quote;
    logic [10:0] pos_next;
    logic [1:0]  k;
    t_burst      burst;

    // Classify the byte and precompute the saturating position step.
    assign sep      = (i_byte == CH_SPACE) || (i_byte == CH_CR) || (i_byte == CH_LF);
    assign quote    = (i_byte == CH_QUOTE);
    assign pos_next = (r_pos >= POS_CAP) ? POS_CAP : r_pos + 11'd1;

    // Decode the byte, then the end of line, appending results in order.
    always_comb begin
        n_mode = r_mode;
        n_pos  = r_pos;
        n_tok  = r_tok;
        burst  = '0;
        k      = 2'd0;

        unique case (r_mode)
            MODE_BETWEEN: begin
                if (sep) begin
                    n_mode = MODE_BETWEEN;
                end else if (quote) begin
                    n_mode = MODE_QUOTED;
                end else begin
                    burst.res[k] = make_result(EV_BYTE, i_byte, 11'd0, n_tok);
                    k = k + 2'd1;
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_PLAIN: begin
                if (sep) begin
                    burst.res[k] = make_result(EV_END, 8'd0, 11'd0, n_tok);
                    k = k + 2'd1;
                    n_tok  = tok_inc(n_tok);
                    n_mode = MODE_BETWEEN;
                end else begin
                    burst.res[k] = make_result(EV_BYTE, i_byte, 11'd0, n_tok);
                    k = k + 2'd1;
                end
            end
            MODE_QUOTED: begin
                if (quote) begin
                    n_mode = MODE_QUOTE_SEEN;
                end else begin
                    burst.res[k] = make_result(EV_BYTE, i_byte, 11'd0, n_tok);
                    k = k + 2'd1;
                end
            end
            MODE_QUOTE_SEEN: begin
                if (quote) begin
                    // A doubled quote stands for one literal quote.
                    burst.res[k] = make_result(EV_BYTE, CH_QUOTE, 11'd0, n_tok);
                    k = k + 2'd1;
                    n_mode = MODE_QUOTED;
                end else if (sep) begin
                    burst.res[k] = make_result(EV_END, 8'd0, 11'd0, n_tok);
                    k = k + 2'd1;
                    n_tok  = tok_inc(n_tok);
                    n_mode = MODE_BETWEEN;
                end else begin
                    burst.res[k] = make_result(EV_ILL, 8'd0, r_pos, n_tok);
                    k = k + 2'd1;
                    n_mode = MODE_SKIP;
                end
            end
            MODE_SKIP: begin
                n_mode = MODE_SKIP;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase

        if (i_eol) begin
            unique case (n_mode)
                MODE_PLAIN, MODE_QUOTE_SEEN: begin
                    burst.res[k] = make_result(EV_END, 8'd0, 11'd0, n_tok);
                    k = k + 2'd1;
                    n_tok = tok_inc(n_tok);
                    burst.res[k] = make_result(EV_OK, 8'd0, 11'd0, n_tok);
                    k = k + 2'd1;
                end
                MODE_BETWEEN: begin
                    burst.res[k] = make_result((n_tok == 8'd0) ? EV_NOCMD : EV_OK,
                                               8'd0, 11'd0, n_tok);
                    k = k + 2'd1;
                end
                MODE_QUOTED: begin
                    // A quote still open at the end reports at the line length.
                    burst.res[k] = make_result(EV_ILL, 8'd0, pos_next, n_tok);
                    k = k + 2'd1;
                end
                default: begin
                    k = k;
                end
            endcase
            n_mode = MODE_BETWEEN;
            n_pos  = 11'd0;
            n_tok  = 8'd0;
        end else begin
            n_pos = pos_next;
        end

        // Mark the final word of this byte's run.
        burst.count = k;
        if (k != 2'd0) begin
            burst.res[k - 2'd1].last = 1'b1;
        end
    end

    assign o_burst = burst;

    // State register, advanced once per decoded byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BETWEEN;
            r_pos  <= 11'd0;
            r_tok  <= 8'd0;
        end else if (i_load) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_tok  <= n_tok;
        end
    end

    // A count of zero only reaches a no-command event.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_eol && (r_mode == MODE_BETWEEN) && sep && (r_tok == 8'd0))
            |-> (burst.count == 2'd1) && (burst.res[0].kind == EV_NOCMD))
        else $error("separator-only line did not end with no-command");

    // While skipping, no byte produces a result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SKIP) |-> (burst.count == 2'd0))
        else $error("skipped byte produced a result");

    // The position never runs past its cap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CAP)
        else $error("byte position beyond its cap");

endmodule

>>> rtl/core/quoted_command_line_tokenizer_core.sv
// ============================================================================
// quoted_command_line_tokenizer_core: streaming command line tokenizer
// Takes one byte per word and sustains one byte per cycle while each byte
// yields at most one result and the receiver does not stall; a byte that
// yields two or three results (a line event with a token end or a token byte)
// holds the input until the buffer's last word is taken, since the result
// buffer sends one word a cycle. An input byte passes an input register, then
// the decode into the result buffer. Separators are space, CR and LF; quoted
// tokens use a doubled quote as an escape. After an ill-formed string the rest
// of the line is dropped and the line is closed silently at its end.
// ============================================================================
module quoted_command_line_tokenizer_core import qclt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_line,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_char_out,
    output logic [10:0] o_position,
    output logic [7:0]  o_token_number,
    output logic        o_last_of_run
);

    logic          r_in_vld;
    logic [7:0]    r_byte;
    logic          r_eol;
    t_result [2:0] r_buf;
    logic [1:0]    r_cnt;

    logic          take;
    logic          load;
    logic          in_acc;
    t_burst        burst;

    // Handshake: the buffer reloads when empty or when its last word leaves.
    assign take    = (r_cnt != 2'd0) && !i_stall;
    assign load    = r_in_vld && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && take));
    assign o_stall = r_in_vld && !load;
    assign in_acc  = i_valid && !o_stall;

    // Scanner state and decode.
    qclt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_byte  (r_byte),
        .i_eol   (r_eol),
        .o_burst (burst)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_byte_in;
            r_eol  <= i_end_of_line;
        end
    end

    // Result buffer: word 0 is presented, the rest shift down as it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= burst.count;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf <= burst.res;
        end else if (take) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    // Output word.
    assign o_valid        = (r_cnt != 2'd0);
    assign o_event_kind   = r_buf[0].kind;
    assign o_char_out     = r_buf[0].ch;
    assign o_position     = r_buf[0].pos;
    assign o_token_number = r_buf[0].tok;
    assign o_last_of_run  = r_buf[0].last;

    // The last word of a run is the last word held in the buffer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_run) |-> (r_cnt == 2'd1))
        else $error("last-of-run flag with more words buffered");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !r_buf[0].last)
        else $error("run ended early in the result buffer");

    // Only token bytes carry a character, only errors carry a position.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_kind != EV_BYTE)) |-> (o_char_out == 8'd0))
        else $error("character on a non-byte event");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_kind != EV_ILL)) |-> (o_position == 11'd0))
        else $error("position on a non-error event");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the quoted command line tokenizer
// Feeds command lines one byte per word, predicts every result word in the
// bench and checks each one against the oldest prediction, with random idle
// cycles on both sides and one long receiver hold-off.
// ============================================================================
module tb import qclt_pkg::*; ();

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 435;

    // One input word with the idle cycles that precede it.
    typedef struct {
        logic [7:0]  data;
        logic        eol;
        int unsigned gap;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        in_eol = 1'b0;
    logic        out_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_char_out;
    logic [10:0] o_position;
    logic [7:0]  o_token_number;
    logic        o_last_of_run;

    t_stim       byte_feed_q[$];
    logic [7:0]  line_buf[$];
    t_result     want_q[$];

    // Scanner state as the bench tracks it.
    t_mode       scan_mode_m = MODE_BETWEEN;
    int          line_pos_m = 0;
    int          tok_count_m = 0;

    int          err_cnt = 0;
    int          n_bytes = 0;
    int          n_lines = 0;
    int          n_results = 0;
    int          n_ends = 0;
    int          n_ok = 0;
    int          n_ill = 0;
    int          n_nocmd = 0;
    int          rnd_bytes = 0;
    logic        pressure_on = 1'b0;

    quoted_command_line_tokenizer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .o_stall        (o_stall),
        .i_byte_in      (in_byte),
        .i_end_of_line  (in_eol),
        .o_valid        (o_valid),
        .i_stall        (out_stall),
        .o_event_kind   (o_event_kind),
        .o_char_out     (o_char_out),
        .o_position     (o_position),
        .o_token_number (o_token_number),
        .o_last_of_run  (o_last_of_run)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit is_sep(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // Append one byte to the line being built.
    function automatic void line_add(logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    // Queue one predicted result word tagged with the current token count.
    function automatic void push_event(t_event kind, logic [7:0] ch, int pos);
        t_result r;
        int p;
        int t;
        p = (pos > MAX_LINE) ? MAX_LINE : pos;
        if (p > 2047) p = 2047;
        t = (tok_count_m > 255) ? 255 : tok_count_m;
        r.kind = kind;
        r.ch   = ch;
        r.pos  = p[10:0];
        r.tok  = t[7:0];
        r.last = 1'b0;
        want_q.insert(want_q.size(), r);
    endfunction

    function automatic void close_token();
        if (tok_count_m < MAX_TOKENS) tok_count_m++;
    endfunction

    // Advance the tracked scanner by one byte and queue what it produces.
    function automatic void scan_byte(logic [7:0] b, logic eol);
        int n0;
        int pos;
        bit sep;
        bit quote;
        t_result r;
        n0 = want_q.size();
        pos = line_pos_m;
        sep = is_sep(b);
        quote = (b == CH_QUOTE);
        case (scan_mode_m)
            MODE_BETWEEN: begin
                if (quote) begin
                    scan_mode_m = MODE_QUOTED;
                end else if (!sep) begin
                    push_event(EV_BYTE, b, 0);
                    scan_mode_m = MODE_PLAIN;
                end
            end
            MODE_PLAIN: begin
                if (sep) begin
                    push_event(EV_END, 8'h00, 0);
                    close_token();
                    scan_mode_m = MODE_BETWEEN;
                end else begin
                    push_event(EV_BYTE, b, 0);
                end
            end
            MODE_QUOTED: begin
                if (quote) scan_mode_m = MODE_QUOTE_SEEN;
                else push_event(EV_BYTE, b, 0);
            end
            MODE_QUOTE_SEEN: begin
                if (quote) begin
                    push_event(EV_BYTE, CH_QUOTE, 0);
                    scan_mode_m = MODE_QUOTED;
                end else if (sep) begin
                    push_event(EV_END, 8'h00, 0);
                    close_token();
                    scan_mode_m = MODE_BETWEEN;
                end else begin
                    push_event(EV_ILL, 8'h00, pos);
                    scan_mode_m = MODE_SKIP;
                end
            end
            default: begin
            end
        endcase

        // The end of the line closes whatever is open and resets the scanner.
        if (eol) begin
            case (scan_mode_m)
                MODE_PLAIN, MODE_QUOTE_SEEN: begin
                    push_event(EV_END, 8'h00, 0);
                    close_token();
                    push_event(EV_OK, 8'h00, 0);
                end
                MODE_BETWEEN: push_event((tok_count_m == 0) ? EV_NOCMD : EV_OK, 8'h00, 0);
                MODE_QUOTED: push_event(EV_ILL, 8'h00, pos + 1);
                default: begin
                end
            endcase
            scan_mode_m = MODE_BETWEEN;
            line_pos_m = 0;
            tok_count_m = 0;
        end else begin
            line_pos_m = (pos >= MAX_LINE) ? MAX_LINE : pos + 1;
        end

        if (want_q.size() > n0) begin
            r = want_q.pop_back();
            r.last = 1'b1;
            want_q.insert(want_q.size(), r);
        end
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (is_sep(v) || v == CH_QUOTE);
        return v;
    endfunction

    function automatic logic [7:0] sep_byte();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Random byte with quotes and separators made common.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return CH_QUOTE;
            1: return sep_byte();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_seps(input int n);
        int k;
        for (k = 0; k < n; k++) line_add(sep_byte());
    endtask

    task automatic add_plain(input int len);
        int k;
        for (k = 0; k < len; k++) line_add(plain_byte());
    endtask

    task automatic add_noise(input int len);
        int k;
        for (k = 0; k < len; k++) line_add(noise_byte());
    endtask

    // Quoted token with random content; inner quotes are always doubled.
    task automatic add_quoted(input int len, input bit closed);
        int k;
        logic [7:0] v;
        line_add(CH_QUOTE);
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    line_add(CH_QUOTE);
                    line_add(CH_QUOTE);
                end
                1: line_add(sep_byte());
                default: begin
                    v = 8'($urandom_range(0, 255));
                    if (v == CH_QUOTE) line_add(CH_QUOTE);
                    line_add(v);
                end
            endcase
        end
        if (closed) line_add(CH_QUOTE);
    endtask

    // Move the line being built to the feed, flagging its last byte.
    task automatic queue_line(input bit fast);
        int k;
        t_stim s;
        for (k = 0; k < line_buf.size(); k++) begin
            s.data = line_buf[k];
            s.eol  = (k == line_buf.size() - 1);
            s.gap  = fast ? 0 : $urandom_range(0, 17);
            byte_feed_q.insert(byte_feed_q.size(), s);
        end
        line_buf.delete();
        n_lines++;
    endtask

    // Mostly well-formed lines, plus broken quotes and plain noise.
    task automatic add_random_line();
        int shape;
        int ntok;
        int k;
        shape = $urandom_range(0, 9);
        if (shape == 8) begin
            add_noise($urandom_range(1, 12));
        end else if (shape == 9) begin
            add_noise($urandom_range(1, 2));
        end else begin
            if ($urandom_range(0, 2) == 0) add_seps($urandom_range(1, 3));
            ntok = $urandom_range(0, 6);
            for (k = 0; k < ntok; k++) begin
                if (k > 0) add_seps($urandom_range(1, 3));
                if ($urandom_range(0, 1) == 0) add_plain($urandom_range(1, 6));
                else add_quoted($urandom_range(0, 6), 1'b1);
            end
            if (shape == 6) begin
                // Closing quote followed by an ordinary byte, then junk.
                if (ntok > 0) add_seps($urandom_range(1, 2));
                add_quoted($urandom_range(0, 4), 1'b1);
                line_add(plain_byte());
                add_noise($urandom_range(0, 5));
            end else if (shape == 7) begin
                if (ntok > 0) add_seps($urandom_range(1, 2));
                add_quoted($urandom_range(0, 6), 1'b0);
            end else if ($urandom_range(0, 2) == 0) begin
                add_seps($urandom_range(1, 3));
            end
        end
        if (line_buf.size() == 0) line_add(sep_byte());
    endtask

    // Reset, stimulus, and the end of the run.
    initial begin : stimulus
        bit fast;

        // Two tokens with the byte extremes; the last ends three results.
        line_buf = '{8'h00, CH_SPACE, 8'hFF};
        queue_line(1'b0);
        // Doubled quote inside a quoted token, then a plain one at the end.
        line_buf = '{CH_QUOTE, "x", CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_CR, "z"};
        queue_line(1'b0);
        // Empty quoted token closed by the end of the line.
        line_buf = '{CH_QUOTE, CH_QUOTE};
        queue_line(1'b0);
        // Ill-formed string mid-line; the rest of the line is dropped.
        line_buf = '{CH_QUOTE, "a", CH_QUOTE, "b", CH_SPACE, "c"};
        queue_line(1'b0);
        // Separators only.
        line_buf = '{CH_SPACE, CH_CR, CH_LF};
        queue_line(1'b0);
        // Quote still open at the end of the line.
        line_buf = '{CH_QUOTE, "a"};
        queue_line(1'b0);
        // Token closed by a separator that is the last byte.
        line_buf = '{"a", CH_SPACE};
        queue_line(1'b0);

        while (rnd_bytes < RANDOM_BYTES) begin
            add_random_line();
            rnd_bytes += line_buf.size();
            fast = ($urandom_range(0, 3) == 0);
            queue_line(fast);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed_q.size() > 0 || in_valid || want_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d bytes in %0d lines, %0d results checked",
                 n_bytes, n_lines, n_results);
        $display("  %0d token ends, %0d lines ok, %0d ill-formed, %0d without a command",
                 n_ends, n_ok, n_ill, n_nocmd);
        if (err_cnt == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Sender: offers the next word after its idle cycles, holds it while stalled.
    always @(posedge i_clk) begin : sender
        int unsigned gap_left;
        bit gap_loaded;
        t_stim cur;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_byte <= 8'h00;
            in_eol <= 1'b0;
            gap_left = 0;
            gap_loaded = 1'b0;
        end else begin
            if (in_valid && !o_stall) begin
                scan_byte(in_byte, in_eol);
                n_bytes++;
            end
            if (!(in_valid && o_stall)) begin
                if (!gap_loaded && byte_feed_q.size() > 0) begin
                    gap_left = byte_feed_q[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_loaded && gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_feed_q.size() > 0) begin
                    cur = byte_feed_q.pop_front();
                    in_valid <= 1'b1;
                    in_byte <= cur.data;
                    in_eol <= cur.eol;
                    gap_loaded = 1'b0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once the run is under way, so the block backs up.
    always @(posedge i_clk) begin : hold_off
        int hold_cnt;
        bit hold_done;
        if (!i_rst_n) begin
            pressure_on <= 1'b0;
            hold_cnt = 0;
            hold_done = 1'b0;
        end else if (!hold_done && !pressure_on && n_bytes >= 150) begin
            pressure_on <= 1'b1;
            hold_cnt = 0;
        end else if (pressure_on) begin
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) begin
                pressure_on <= 1'b0;
                hold_done = 1'b1;
            end
        end
    end

    task automatic report(input string field, input int want, input int got);
        err_cnt++;
        $display("%0t ns: mismatch on %s, expected %0d, actual %0d",
                 $time, field, want, got);
    endtask

    // Receiver: checks each accepted word, then stalls for a random count, or not at all in burst mode.
    always @(posedge i_clk) begin : receiver
        int unsigned rcv_wait;
        bit rcv_burst;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rcv_wait = 0;
            rcv_burst = 1'b0;
        end else begin
            if (o_valid && !out_stall) begin
                got.kind = t_event'(o_event_kind);
                got.ch   = o_char_out;
                got.pos  = o_position;
                got.tok  = o_token_number;
                got.last = o_last_of_run;
                n_results++;
                if (want_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: result with none expected, kind %0d char %0d",
                             $time, o_event_kind, o_char_out);
                end else begin
                    want = want_q.pop_front();
                    if (got.kind != want.kind) report("event_kind", want.kind, got.kind);
                    if (got.ch != want.ch) report("char_out", want.ch, got.ch);
                    if (got.pos != want.pos) report("position", want.pos, got.pos);
                    if (got.tok != want.tok) report("token_number", want.tok, got.tok);
                    if (got.last != want.last) report("last_of_run", want.last, got.last);
                    case (want.kind)
                        EV_END: n_ends++;
                        EV_OK: n_ok++;
                        EV_ILL: n_ill++;
                        EV_NOCMD: n_nocmd++;
                        default: begin
                        end
                    endcase
                end
                rcv_wait = rcv_burst ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 39) == 0) rcv_burst = !rcv_burst;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
            end
            out_stall <= pressure_on || (rcv_wait > 0);
        end
    end

    // Watchdog: too long without a word moving on either side ends the run.
    always @(posedge i_clk) begin : watchdog
        int idle_cnt;
        if (!i_rst_n || (in_valid && !o_stall) || (o_valid && !out_stall)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
        end
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("%0t ns: no word accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule
